// ===== src/lru_frame_replacer_core_assert.svh =====
// assertion macros used by the lru frame replacer datapath
`ifndef LRU_FRAME_REPLACER_CORE_ASSERT_SVH
`define LRU_FRAME_REPLACER_CORE_ASSERT_SVH

// property that must hold at every edge out of reset
`define LFR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define LFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/lfr_pkg.sv =====
// shared types and constants of the lru frame replacer
package lfr_pkg;

    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;
    localparam int ACTION_W = 2;
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UNPIN  = 2'd0,
        ACT_PIN    = 2'd1,
        ACT_VICTIM = 2'd2,
        ACT_SIZE   = 2'd3
    } t_action;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// ===== src/lfr_ctrl.sv =====
// controller state machine of the lru frame replacer
module lfr_ctrl
    import lfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_in_stall;

    assign o_in_stall = r_in_stall;
    assign o_cmd.load = i_in_valid && !r_in_stall;
    assign o_cmd.exec = (r_state == S_EXEC) && !i_status.out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_EXEC;
                        r_in_stall <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (!i_status.out_busy) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== src/lfr_datapath.sv =====
// link memories, list registers and result register of the lru frame replacer
`include "lru_frame_replacer_core_assert.svh"

module lfr_datapath
    import lfr_pkg::*;
#(
    parameter int MAX_FRAMES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [COUNT_W-1:0]  i_capacity,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [FRAME_W-1:0]  i_frame,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found,
    output logic [FRAME_W-1:0]  o_victim_frame,
    output logic [COUNT_W-1:0]  o_tracked_count
);

    localparam int IW = $clog2(MAX_FRAMES);

    logic [IW-1:0] r_next_mem [MAX_FRAMES];
    logic [IW-1:0] r_prev_mem [MAX_FRAMES];

    logic [MAX_FRAMES-1:0] r_tracked;
    logic [IW-1:0]         r_oldest;
    logic [IW-1:0]         r_newest;
    logic [COUNT_W-1:0]    r_count;

    t_action               r_action;
    logic [FRAME_W-1:0]    r_frame;
    logic [IW-1:0]         r_uidx;
    logic [IW-1:0]         r_rd_next;
    logic [IW-1:0]         r_rd_prev;

    logic                  r_out_valid;
    logic                  r_found;
    logic [FRAME_W-1:0]    r_vf;
    logic [COUNT_W-1:0]    r_cnt;

    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         fidx;
    logic                  fr_ok;
    logic                  is_tr;
    logic                  do_unpin;
    logic                  do_unlink;
    logic                  empty;

    logic                  next_we;
    logic [IW-1:0]         next_wa;
    logic [IW-1:0]         next_wd;
    logic                  prev_we;
    logic [IW-1:0]         prev_wa;
    logic [IW-1:0]         prev_wd;

    logic [IW-1:0]         n_oldest;
    logic [IW-1:0]         n_newest;
    logic [COUNT_W-1:0]    n_count;
    logic                  n_found;
    logic [FRAME_W-1:0]    n_vf;

    assign rd_addr = (t_action'(i_action) == ACT_VICTIM) ? r_oldest : IW'(i_frame);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= t_action'(i_action);
            r_frame   <= i_frame;
            r_uidx    <= rd_addr;
            r_rd_next <= r_next_mem[rd_addr];
        end
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_prev <= r_prev_mem[rd_addr];
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
    end

    assign fidx      = IW'(r_frame);
    assign fr_ok     = 32'(r_frame) < MAX_FRAMES;
    assign is_tr     = r_tracked[fidx];
    assign empty     = (r_count == '0);
    assign do_unpin  = (r_action == ACT_UNPIN) && fr_ok && !is_tr && (r_count < i_capacity);
    assign do_unlink = ((r_action == ACT_PIN) && fr_ok && is_tr) ||
                       ((r_action == ACT_VICTIM) && !empty);

    always_comb begin
        next_we  = 1'b0;
        next_wa  = r_newest;
        next_wd  = fidx;
        prev_we  = 1'b0;
        prev_wa  = fidx;
        prev_wd  = r_newest;
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_count  = r_count;
        n_found  = !((r_action == ACT_VICTIM) && empty);
        n_vf     = ((r_action == ACT_VICTIM) && !empty) ? FRAME_W'(r_oldest) : '0;
        if (do_unpin) begin
            if (empty) begin
                n_oldest = fidx;
            end else begin
                next_we = i_cmd.exec;
                prev_we = i_cmd.exec;
            end
            n_newest = fidx;
            n_count  = r_count + 1'b1;
        end else if (do_unlink) begin
            if (r_count == COUNT_W'(1)) begin
                n_oldest = '0;
                n_newest = '0;
            end else if (r_uidx == r_oldest) begin
                n_oldest = r_rd_next;
            end else if (r_uidx == r_newest) begin
                n_newest = r_rd_prev;
            end else begin
                next_we = i_cmd.exec;
                next_wa = r_rd_prev;
                next_wd = r_rd_next;
                prev_we = i_cmd.exec;
                prev_wa = r_rd_next;
                prev_wd = r_rd_prev;
            end
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked   <= '0;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_oldest <= n_oldest;
                r_newest <= n_newest;
                r_count  <= n_count;
                if (do_unpin) begin
                    r_tracked[fidx] <= 1'b1;
                end
                if (do_unlink) begin
                    r_tracked[r_uidx] <= 1'b0;
                end
            end
            r_out_valid <= i_cmd.exec || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_found <= n_found;
            r_vf    <= n_vf;
            r_cnt   <= n_count;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_victim_frame    = r_vf;
    assign o_tracked_count   = r_cnt;

    `LFR_ASSERT_ALWAYS(a_count_matches_tracked, i_clk, i_rst_n, COUNT_W'($countones(r_tracked)) == r_count, "tracked bits disagree with count")
    `LFR_ASSERT_IMPL(a_empty_ends_zero, i_clk, i_rst_n, empty, (r_oldest == '0) && (r_newest == '0), "empty list with nonzero ends")
    `LFR_ASSERT_IMPL(a_ends_tracked, i_clk, i_rst_n, !empty, r_tracked[r_oldest] && r_tracked[r_newest], "list end not tracked")

endmodule

// ===== src/lru_frame_replacer_core.sv =====
// top level of the lru frame replacer with its configuration port
//
// Keeps evictable frames in least-recently-unpinned order as a doubly linked
// list in two single-port link memories. For each item, the accept cycle
// reads both link memories at the frame (or oldest frame for a victim
// request), and the execute state then updates the neighbor links and list
// registers and loads the result register; no new item is accepted until
// the current one has executed. A result held under i_out_stall does not
// block the accept of the next item, but holds that item in its execute
// state, with o_in_stall high, until the held result is taken. Link
// entries need no initialization; tracked bits clear at reset, with no
// clearing pass. capacity (reset 64) lies at byte address 0 and should be
// written only while the block is idle.
module lru_frame_replacer_core
    import lfr_pkg::*;
#(
    parameter int MAX_FRAMES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [FRAME_W-1:0]  i_frame,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found,
    output logic [FRAME_W-1:0]  o_victim_frame,
    output logic [COUNT_W-1:0]  o_tracked_count,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic REG_CAPACITY = 1'b0;

    logic [COUNT_W-1:0] r_capacity;
    t_dp_cmd            cmd;
    t_dp_status         status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-COUNT_W){1'b0}}, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[COUNT_W-1:0];
        end
    end

    lfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfr_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_capacity      (r_capacity),
        .i_action        (i_action),
        .i_frame         (i_frame),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_victim_frame  (o_victim_frame),
        .o_tracked_count (o_tracked_count)
    );

endmodule
